[rtl/usd_pkg.sv]
`timescale 1ns / 1ps

package usd_pkg;

  // Widths of the word fields.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned UsedW  = 3;
  localparam int unsigned OutDataW = 24;

  localparam logic [CpW-1:0] ReplacementChar = 21'h00FFFD;
  localparam logic [CpW-1:0] SurrLo          = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi          = 21'h00DFFF;
  localparam logic [CpW-1:0] MaxScalar       = 21'h10FFFF;

  // Sequence lengths held in the decoder state.
  localparam logic [UsedW-1:0] LenNone = 3'd0;
  localparam logic [UsedW-1:0] LenOne  = 3'd1;
  localparam logic [UsedW-1:0] LenTwo  = 3'd2;
  localparam logic [UsedW-1:0] LenThree = 3'd3;
  localparam logic [UsedW-1:0] LenFour = 3'd4;

  typedef enum logic [2:0] {
    CLS_CONT    = 3'd0,
    CLS_ASCII   = 3'd1,
    CLS_LEAD2   = 3'd2,
    CLS_LEAD3   = 3'd3,
    CLS_LEAD4   = 3'd4,
    CLS_ILLEGAL = 3'd5
  } byte_class_e;

  typedef struct packed {
    logic [CpW-1:0]   code_point;
    logic [UsedW-1:0] bytes_used;
    logic             was_invalid;
    logic             last_of_run;
  } result_t;

  // One queue entry holds everything a single input byte produced.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  function automatic byte_class_e classify(logic [ByteW-1:0] b);
    byte_class_e c;
    if (b[7] == 1'b0) begin
      c = CLS_ASCII;
    end else if (b[7:6] == 2'b10) begin
      c = CLS_CONT;
    end else if (b[7:5] == 3'b110) begin
      c = CLS_LEAD2;
    end else if (b[7:4] == 4'b1110) begin
      c = CLS_LEAD3;
    end else if (b[7:3] == 5'b11110) begin
      c = CLS_LEAD4;
    end else begin
      c = CLS_ILLEGAL;
    end
    return c;
  endfunction

  // True when a finished sequence of the given length holds a legal,
  // shortest-form scalar outside the surrogate range.
  function automatic logic scalar_ok(logic [UsedW-1:0] len, logic [CpW-1:0] v);
    logic in_len;
    unique case (len)
      LenTwo:   in_len = (v >= 21'h000080) && (v <= 21'h0007FF);
      LenThree: in_len = (v >= 21'h000800) && (v <= 21'h00FFFF);
      LenFour:  in_len = (v >= 21'h010000) && (v <= MaxScalar);
      default:  in_len = 1'b0;
    endcase
    return in_len && !((v >= SurrLo) && (v <= SurrHi));
  endfunction

endpackage

[rtl/usd_front.sv]
`timescale 1ns / 1ps

module usd_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [usd_pkg::ByteW-1:0]  s_axis_tdata,
  input  logic                       q_full_i,
  output logic                       push_o,
  output usd_pkg::entry_t            push_entry_o
);

  logic [usd_pkg::CpW-1:0]   part_q, part_d;
  logic [usd_pkg::UsedW-1:0] exp_q, exp_d;
  logic [usd_pkg::UsedW-1:0] seen_q, seen_d;

  usd_pkg::byte_class_e      cls;
  logic                      accept;
  logic                      seq_open;
  logic                      fr_valid;
  usd_pkg::result_t          fr_res;
  logic [usd_pkg::UsedW-1:0] fr_exp;
  logic [usd_pkg::CpW-1:0]   fr_part;
  logic [usd_pkg::CpW-1:0]   acc;
  logic [usd_pkg::UsedW-1:0] seen_inc;
  logic                      ok;

  assign s_axis_tready = !q_full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cls           = usd_pkg::classify(s_axis_tdata);
  assign seq_open      = (exp_q >= usd_pkg::LenTwo) && (exp_q <= usd_pkg::LenFour);
  assign acc           = {part_q[usd_pkg::CpW-7:0], s_axis_tdata[5:0]};
  assign seen_inc      = seen_q + usd_pkg::LenOne;
  assign ok            = usd_pkg::scalar_ok(exp_q, acc);

  // Handling of a byte that arrives with no sequence open.
  always_comb begin
    fr_valid = 1'b0;
    fr_res   = '0;
    fr_exp   = usd_pkg::LenNone;
    fr_part  = '0;
    unique case (cls)
      usd_pkg::CLS_ASCII: begin
        fr_valid = 1'b1;
        fr_res   = '{code_point: usd_pkg::CpW'(s_axis_tdata), bytes_used: usd_pkg::LenOne,
                     was_invalid: 1'b0, last_of_run: 1'b1};
      end
      usd_pkg::CLS_LEAD2: begin
        fr_exp  = usd_pkg::LenTwo;
        fr_part = usd_pkg::CpW'(s_axis_tdata[4:0]);
      end
      usd_pkg::CLS_LEAD3: begin
        fr_exp  = usd_pkg::LenThree;
        fr_part = usd_pkg::CpW'(s_axis_tdata[3:0]);
      end
      usd_pkg::CLS_LEAD4: begin
        fr_exp  = usd_pkg::LenFour;
        fr_part = usd_pkg::CpW'(s_axis_tdata[2:0]);
      end
      default: begin
        fr_valid = 1'b1;
        fr_res   = '{code_point: usd_pkg::ReplacementChar, bytes_used: usd_pkg::LenOne,
                     was_invalid: 1'b1, last_of_run: 1'b1};
      end
    endcase
  end

  always_comb begin
    part_d       = part_q;
    exp_d        = exp_q;
    seen_d       = seen_q;
    push_o       = 1'b0;
    push_entry_o = '0;
    if (accept) begin
      if (!seq_open) begin
        push_o          = fr_valid;
        push_entry_o.r0 = fr_res;
        exp_d           = fr_valid ? usd_pkg::LenNone : fr_exp;
        seen_d          = fr_valid ? usd_pkg::LenNone : usd_pkg::LenOne;
        part_d          = fr_valid ? part_q : fr_part;
      end else if (cls != usd_pkg::CLS_CONT) begin
        // Truncated sequence: report what was consumed, then restart on this byte.
        push_o           = 1'b1;
        push_entry_o.two = fr_valid;
        push_entry_o.r0  = '{code_point: usd_pkg::ReplacementChar, bytes_used: seen_q,
                             was_invalid: 1'b1, last_of_run: !fr_valid};
        push_entry_o.r1  = fr_res;
        exp_d            = fr_valid ? usd_pkg::LenNone : fr_exp;
        seen_d           = fr_valid ? usd_pkg::LenNone : usd_pkg::LenOne;
        part_d           = fr_part;
      end else if (seen_inc < exp_q) begin
        part_d = acc;
        seen_d = seen_inc;
      end else begin
        push_o          = 1'b1;
        push_entry_o.r0 = '{code_point: ok ? acc : usd_pkg::ReplacementChar,
                            bytes_used: exp_q, was_invalid: !ok, last_of_run: 1'b1};
        part_d          = '0;
        exp_d           = usd_pkg::LenNone;
        seen_d          = usd_pkg::LenNone;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0;
      exp_q  <= usd_pkg::LenNone;
      seen_q <= usd_pkg::LenNone;
    end else begin
      part_q <= part_d;
      exp_q  <= exp_d;
      seen_q <= seen_d;
    end
  end

endmodule

[rtl/usd_queue.sv]
`timescale 1ns / 1ps

module usd_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  usd_pkg::entry_t push_entry_i,
  input  logic            pop_i,
  output usd_pkg::entry_t head_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  usd_pkg::entry_t  slots_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[rtl/usd_back.sv]
`timescale 1ns / 1ps

module usd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  usd_pkg::entry_t               head_i,
  input  logic                          empty_i,
  output logic                          pop_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [usd_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast
);

  logic             valid_q, valid_d;
  usd_pkg::result_t res_q, res_d;
  logic             phase_q, phase_d;
  logic             load;
  usd_pkg::result_t cur;

  // Phase selects the second result of a two-result entry.
  assign cur  = phase_q ? head_i.r1 : head_i.r0;
  assign load = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    phase_d = phase_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        res_d = cur;
        if (head_i.two && !phase_q) begin
          phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          pop_o   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {res_q.bytes_used, res_q.code_point};
  assign m_axis_tuser  = res_q.was_invalid;
  assign m_axis_tlast  = res_q.last_of_run;

endmodule

[rtl/utf8_stream_decoder.sv]
// A byte is written into the entry queue when it is accepted, and its first code point
// is then loaded from the queue head into the output register.
// Throughput: one byte per cycle in while the queue is not full and one code point per
// cycle out while the sink is ready; a byte that closes a truncated sequence and also
// stands alone yields two code points, which the entry queue between the halves absorbs.
// Reset (rst_ni low, asynchronous) closes any open sequence, empties the queue
// and drops the output valid.
`timescale 1ns / 1ps

module utf8_stream_decoder #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Byte input. tdata: data_byte [7:0].
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [usd_pkg::ByteW-1:0]     s_axis_tdata,
  // Code point output. tdata: code_point [20:0], bytes_used [23:21].
  // tuser: was_invalid. tlast: last_of_run, set on the final word a byte causes.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [usd_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast
);

  // The front half owns the sequence state (accumulator, expected length, count)
  // and turns each byte combinationally into zero, one or two results. Bytes
  // that produce results become one queue entry; the back half drains entries
  // one word per cycle, while the sink is ready, into a registered output stage.
  logic            push;
  usd_pkg::entry_t push_entry;
  logic            q_full;
  logic            q_empty;
  logic            pop;
  usd_pkg::entry_t head;

  usd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_entry_o  (push_entry)
  );

  usd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .full_o       (q_full),
    .empty_o      (q_empty)
  );

  // The output register holds a finished word while it waits for the sink; the
  // front keeps taking bytes into the entry queue until the queue fills.
  usd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (q_empty),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

[rtl/usd_checker.sv]
`timescale 1ns / 1ps

module usd_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [usd_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          m_axis_tuser,
  input  logic                          m_axis_tlast
);

  logic [usd_pkg::CpW-1:0]   cp;
  logic [usd_pkg::UsedW-1:0] used;

  assign cp   = m_axis_tdata[usd_pkg::CpW-1:0];
  assign used = m_axis_tdata[usd_pkg::OutDataW-1:usd_pkg::CpW];

  // A stalled output word must not change.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
       && $stable(m_axis_tlast)))
    else $error("output word changed while stalled");

  // Only the replacement for a truncated sequence is followed by a second word.
  a_first_is_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> m_axis_tuser)
    else $error("non-final word is not a replacement");

  // A flagged word always carries U+FFFD.
  a_bad_is_fffd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (cp == usd_pkg::ReplacementChar))
    else $error("invalid word without replacement character");

  // A good word is a Unicode scalar from one to four bytes.
  a_good_scalar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |->
      ((cp <= usd_pkg::MaxScalar) && !((cp >= usd_pkg::SurrLo) && (cp <= usd_pkg::SurrHi))
       && (used >= usd_pkg::LenOne) && (used <= usd_pkg::LenFour)))
    else $error("valid word is not a legal scalar");

endmodule

bind utf8_stream_decoder usd_checker u_usd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned ByteTarget  = 1750;
  localparam int unsigned HoldAt      = 500;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainAt     = 1000;
  localparam int unsigned QuietAt     = 1500;
  localparam int unsigned ReportLimit = 10;

  // One directed row: the byte, and a hand-written result where it is obvious.
  typedef struct packed {
    logic [usd_pkg::ByteW-1:0] data;
    logic                      typed;
    usd_pkg::result_t          want;
  } stim_row_t;

  localparam int unsigned DirRows = 24;
  localparam stim_row_t DirTable [DirRows] = '{
    '{8'h00, 1'b1, '{21'h000000, usd_pkg::LenOne, 1'b0, 1'b1}},
    '{8'h7F, 1'b1, '{21'h00007F, usd_pkg::LenOne, 1'b0, 1'b1}},
    '{8'h80, 1'b1, '{usd_pkg::ReplacementChar, usd_pkg::LenOne, 1'b1, 1'b1}},
    '{8'hFF, 1'b1, '{usd_pkg::ReplacementChar, usd_pkg::LenOne, 1'b1, 1'b1}},
    '{8'hC2, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'hE2, 1'b0, '0},
    '{8'h41, 1'b0, '0},
    '{8'hE0, 1'b0, '0},
    '{8'hA0, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'hF0, 1'b0, '0},
    '{8'hC3, 1'b0, '0},
    '{8'hA9, 1'b0, '0},
    '{8'hED, 1'b0, '0},
    '{8'hA0, 1'b0, '0},
    '{8'h80, 1'b1, '{usd_pkg::ReplacementChar, usd_pkg::LenThree, 1'b1, 1'b1}},
    '{8'hF4, 1'b0, '0},
    '{8'h8F, 1'b0, '0},
    '{8'hBF, 1'b0, '0},
    '{8'hBF, 1'b0, '0},
    '{8'hC0, 1'b0, '0},
    '{8'h80, 1'b1, '{usd_pkg::ReplacementChar, usd_pkg::LenTwo, 1'b1, 1'b1}},
    '{8'hF8, 1'b1, '{usd_pkg::ReplacementChar, usd_pkg::LenOne, 1'b1, 1'b1}}
  };

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [usd_pkg::ByteW-1:0]    s_axis_tdata;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [usd_pkg::OutDataW-1:0] m_axis_tdata;
  logic                         m_axis_tuser;
  logic                         m_axis_tlast;

  utf8_stream_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Decoder state as the testbench tracks it.
  logic [usd_pkg::CpW-1:0]   payload_acc;
  logic [usd_pkg::UsedW-1:0] open_len;
  logic [usd_pkg::UsedW-1:0] taken_cnt;

  usd_pkg::result_t cp_due_q[$];

  int unsigned sent_cnt;
  int unsigned word_cnt;
  int unsigned replaced_cnt;
  int unsigned pair_cnt;
  int unsigned mismatch_cnt;
  bit          quiet;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic usd_pkg::byte_class_e sort_byte(logic [usd_pkg::ByteW-1:0] b);
    usd_pkg::byte_class_e c;
    unique casez (b)
      8'b0???????: c = usd_pkg::CLS_ASCII;
      8'b10??????: c = usd_pkg::CLS_CONT;
      8'b110?????: c = usd_pkg::CLS_LEAD2;
      8'b1110????: c = usd_pkg::CLS_LEAD3;
      8'b11110???: c = usd_pkg::CLS_LEAD4;
      default:     c = usd_pkg::CLS_ILLEGAL;
    endcase
    return c;
  endfunction

  // Appends a word to the list of words still owed by the decoder.
  function automatic void book_word(input usd_pkg::result_t r);
    cp_due_q.insert(cp_due_q.size(), r);
  endfunction

  // A byte seen with no sequence open: ASCII and bad bytes give one word,
  // a lead opens a sequence and gives nothing.
  function automatic int start_fresh(logic [usd_pkg::ByteW-1:0] b,
                                     output usd_pkg::result_t r);
    usd_pkg::byte_class_e c;
    c = sort_byte(b);
    r = '0;
    unique case (c)
      usd_pkg::CLS_ASCII: begin
        r = '{{13'd0, b}, usd_pkg::LenOne, 1'b0, 1'b1};
        return 1;
      end
      usd_pkg::CLS_CONT, usd_pkg::CLS_ILLEGAL: begin
        r = '{usd_pkg::ReplacementChar, usd_pkg::LenOne, 1'b1, 1'b1};
        return 1;
      end
      usd_pkg::CLS_LEAD2: payload_acc = {16'd0, b[4:0]};
      usd_pkg::CLS_LEAD3: payload_acc = {17'd0, b[3:0]};
      default:            payload_acc = {18'd0, b[2:0]};
    endcase
    open_len  = c;
    taken_cnt = usd_pkg::LenOne;
    return 0;
  endfunction

  // Advances the tracked state by one byte and returns the words it causes.
  function automatic int decode_byte(logic [usd_pkg::ByteW-1:0] b,
                                     output usd_pkg::result_t r0,
                                     output usd_pkg::result_t r1);
    int n;
    logic ok;
    r0 = '0;
    r1 = '0;
    if (open_len < usd_pkg::LenTwo || open_len > usd_pkg::LenFour) begin
      open_len  = usd_pkg::LenNone;
      taken_cnt = usd_pkg::LenNone;
      return start_fresh(b, r0);
    end
    if (sort_byte(b) != usd_pkg::CLS_CONT) begin
      // The open sequence is cut short; the byte then starts over.
      r0 = '{usd_pkg::ReplacementChar, taken_cnt, 1'b1, 1'b0};
      open_len    = usd_pkg::LenNone;
      taken_cnt   = usd_pkg::LenNone;
      payload_acc = '0;
      n = start_fresh(b, r1);
      if (n == 0) r0.last_of_run = 1'b1;
      return 1 + n;
    end
    payload_acc = {payload_acc[usd_pkg::CpW-7:0], b[5:0]};
    taken_cnt   = taken_cnt + 1'b1;
    if (taken_cnt < open_len) return 0;
    unique case (open_len)
      usd_pkg::LenTwo: begin
        ok = payload_acc >= 21'h000080 && payload_acc <= 21'h0007FF;
      end
      usd_pkg::LenThree: begin
        ok = payload_acc >= 21'h000800 && payload_acc <= 21'h00FFFF &&
             !(payload_acc >= usd_pkg::SurrLo && payload_acc <= usd_pkg::SurrHi);
      end
      default: begin
        ok = payload_acc >= 21'h010000 && payload_acc <= usd_pkg::MaxScalar;
      end
    endcase
    if (ok) begin
      r0 = '{payload_acc, open_len, 1'b0, 1'b1};
    end else begin
      r0 = '{usd_pkg::ReplacementChar, open_len, 1'b1, 1'b1};
    end
    open_len    = usd_pkg::LenNone;
    taken_cnt   = usd_pkg::LenNone;
    payload_acc = '0;
    return 1;
  endfunction

  task automatic note_mismatch(input string what, input usd_pkg::result_t want,
                               input usd_pkg::result_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= ReportLimit) begin
      $display("%0t: %s: expected cp=%h used=%0d bad=%b last=%b",
               $realtime, what, want.code_point, want.bytes_used, want.was_invalid,
               want.last_of_run);
      $display("    got cp=%h used=%0d bad=%b last=%b",
               got.code_point, got.bytes_used, got.was_invalid, got.last_of_run);
    end
  endtask

  // Offers one byte, with an occasional gap before it, and books its words
  // once it is taken.
  task automatic send_byte(input logic [usd_pkg::ByteW-1:0] b, input logic typed,
                           input usd_pkg::result_t want);
    int gap;
    int n;
    usd_pkg::result_t r0;
    usd_pkg::result_t r1;
    if (!quiet && $urandom_range(0, 6) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    n = decode_byte(b, r0, r1);
    if (typed) begin
      book_word(want);
    end else begin
      if (n > 0) book_word(r0);
      if (n > 1) book_word(r1);
    end
    if (n > 1) pair_cnt++;
    sent_cnt++;
  endtask

  // One random piece of text: well-formed characters, plus sequences
  // with arbitrary payload, truncated sequences and plain noise.
  task automatic send_unit();
    logic [usd_pkg::ByteW-1:0] seq[$];
    logic [usd_pkg::CpW-1:0] v;
    logic [usd_pkg::ByteW-1:0] lead;
    int kind;
    int len;
    int conts;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      len = $urandom_range(1, 4);
      case (len)
        1: seq.insert(seq.size(), 8'($urandom_range(0, 'h7F)));
        2: begin
          v = 21'($urandom_range('h80, 'h7FF));
          seq.insert(seq.size(), {3'b110, v[10:6]});
          seq.insert(seq.size(), {2'b10, v[5:0]});
        end
        3: begin
          v = 21'($urandom_range('h800, 'hFFFF));
          if (v >= usd_pkg::SurrLo && v <= usd_pkg::SurrHi) v = v ^ 21'h002000;
          seq.insert(seq.size(), {4'b1110, v[15:12]});
          seq.insert(seq.size(), {2'b10, v[11:6]});
          seq.insert(seq.size(), {2'b10, v[5:0]});
        end
        default: begin
          v = 21'($urandom_range('h10000, 'h10FFFF));
          seq.insert(seq.size(), {5'b11110, v[20:18]});
          seq.insert(seq.size(), {2'b10, v[17:12]});
          seq.insert(seq.size(), {2'b10, v[11:6]});
          seq.insert(seq.size(), {2'b10, v[5:0]});
        end
      endcase
    end else begin
      lead = 8'($urandom_range('hC0, 'hF7));
      if (kind < 50) lead = ($urandom_range(0, 1) == 0) ? 8'hED : 8'hE0;
      len = int'(sort_byte(lead));
      if (kind < 65) conts = len - 1;
      else conts = $urandom_range(0, len - 2);
      if (kind < 90) seq.insert(seq.size(), lead);
      repeat (conts) seq.insert(seq.size(), 8'($urandom_range('h80, 'hBF)));
      if (kind >= 80) begin
        repeat ($urandom_range(1, 4)) seq.insert(seq.size(), 8'($urandom_range(0, 255)));
      end
    end
    foreach (seq[i]) send_byte(seq[i], 1'b0, '0);
  endtask

  // Byte source.
  initial begin
    bit drained;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni        = 1'b0;
    payload_acc   = '0;
    open_len      = usd_pkg::LenNone;
    taken_cnt     = usd_pkg::LenNone;
    sent_cnt      = 0;
    word_cnt      = 0;
    replaced_cnt  = 0;
    pair_cnt      = 0;
    mismatch_cnt  = 0;
    quiet         = 1'b0;
    drained       = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DirRows; i++) begin
      send_byte(DirTable[i].data, DirTable[i].typed, DirTable[i].want);
    end

    while (sent_cnt < ByteTarget) begin
      if (!drained && sent_cnt >= DrainAt) begin
        // Let the decoder empty out completely before going on.
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        while (cp_due_q.size() != 0) @(posedge clk_i);
        drained = 1'b1;
      end
      if (sent_cnt >= QuietAt) quiet = 1'b1;
      send_unit();
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (cp_due_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Sent %0d bytes, checked %0d code points, %0d of them replacements.",
             sent_cnt, word_cnt, replaced_cnt);
    $display("%0d bytes ended a broken sequence and gave two words; %0d mismatches.",
             pair_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("utf8_stream_decoder test passed");
    end else begin
      $display("utf8_stream_decoder test failed");
    end
    $finish;
  end

  // Code point sink: random stalls, one long hold-off, none near the end.
  initial begin
    int stall_left;
    int hold_left;
    bit hold_done;
    logic rdy;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && sent_cnt >= HoldAt) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        rdy = 1'b0;
        hold_left--;
      end else if (quiet) begin
        rdy = 1'b1;
      end else if (stall_left > 0) begin
        rdy = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        rdy = 1'b0;
        stall_left = $urandom_range(1, 9) - 1;
      end else begin
        rdy = 1'b1;
      end
      m_axis_tready <= rdy;
    end
  end

  // Compares every accepted word against the oldest booked one.
  initial begin
    usd_pkg::result_t got;
    usd_pkg::result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
        got = '{m_axis_tdata[usd_pkg::CpW-1:0],
                m_axis_tdata[usd_pkg::CpW+usd_pkg::UsedW-1:usd_pkg::CpW],
                m_axis_tuser, m_axis_tlast};
        if (cp_due_q.size() == 0) begin
          note_mismatch("word with nothing pending", '0, got);
        end else begin
          want = cp_due_q.pop_front();
          word_cnt++;
          if (want.was_invalid) replaced_cnt++;
          if (got.code_point !== want.code_point || got.bytes_used !== want.bytes_used ||
              got.was_invalid !== want.was_invalid ||
              got.last_of_run !== want.last_of_run) begin
            note_mismatch("word mismatch", want, got);
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("utf8_stream_decoder test failed");
    $finish;
  end

endmodule
